// ----- sv/bsl_pkg.sv -----
// ----------------------------------------------------------------------------
// bsl_pkg: shared definitions for the bounded sequential list
// Sizes, action codes and the request and result transaction types.
// ----------------------------------------------------------------------------
`default_nettype none

package bsl_pkg;

	localparam int CAPACITY = 16;
	localparam int WORD_W   = 32;
	localparam int POS_W    = 5;
	localparam int CFG_W    = 5;
	localparam int COUNT_W  = 5;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	// Width in which counts, positions and the capacity register are compared.
	localparam int CMP_W    = (CNT_W > CFG_W) ? CNT_W + 1 : CFG_W + 1;

	localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

	typedef logic signed [WORD_W-1:0] word_t;

	typedef enum logic [2:0] {
		ACT_APPEND  = 3'd0,
		ACT_INSERT  = 3'd1,
		ACT_DELETE  = 3'd2,
		ACT_SORT    = 3'd3,
		ACT_REVERSE = 3'd4,
		ACT_DUMP    = 3'd5
	} action_t;

	typedef struct packed {
		action_t            action;
		logic [POS_W-1:0]   position;
		word_t              value;
	} req_t;

	typedef struct packed {
		logic               ok;
		word_t              data;
		logic [COUNT_W-1:0] count;
		logic               last;
	} res_t;

	// One cycle's access to the element memory.
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		word_t            wdata;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

endpackage

`default_nettype wire

// ----- sv/bsl_ram.sv -----
// ----------------------------------------------------------------------------
// bsl_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bsl_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	localparam int AW   = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output      logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- sv/bsl_ctrl.sv -----
// ----------------------------------------------------------------------------
// bsl_ctrl: action sequencer for the bounded sequential list
// Decodes each request and walks the element memory to carry it out.
// ----------------------------------------------------------------------------
`default_nettype none

module bsl_ctrl import bsl_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output      logic             busy,
	input  wire req_t             request,
	input  wire logic [CFG_W-1:0] cap,
	output      logic             done,
	output      res_t             result,
	output      mem_req_t         mem_req,
	input  wire word_t            mem_rdata
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DEC,
		ST_DEL_LD,
		ST_MOVE,
		ST_INS_WR,
		ST_S_LDI,
		ST_S_CMP,
		ST_S_WRI,
		ST_R_RDJ,
		ST_R_WRI,
		ST_R_WRJ,
		ST_DUMP
	} state_t;

	state_t           state_q;
	req_t             req_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] j_q;
	logic [CNT_W-1:0] rem_q;
	logic             pend_q;
	logic [IDX_W-1:0] wdst_q;
	word_t            cur_q;
	word_t            tmp_q;
	logic             done_q;
	res_t             res_q;

	logic [CNT_W-1:0] i_inc, i_dec, i_inc2, j_inc, j_dec, cnt_inc, cnt_dec;
	logic [CMP_W-1:0] cnt_w, cap_w, pos_w;
	logic             full, pos_nz, ins_ok, del_ok, is_insert, swap;
	logic [POS_W-1:0] pos_m1;
	logic [CNT_W-1:0] pos_c;

	function automatic logic [COUNT_W-1:0] count_field(input logic [CNT_W-1:0] v);
		logic [CMP_W-1:0] w;
		w = CMP_W'(v);
		return w[COUNT_W-1:0];
	endfunction

	function automatic res_t mk_res(input logic ok, input word_t data,
	                                input logic [CNT_W-1:0] n, input logic last);
		res_t r;
		r.ok    = ok;
		r.data  = data;
		r.count = count_field(n);
		r.last  = last;
		return r;
	endfunction

	assign i_inc   = i_q + CNT_W'(1);
	assign i_dec   = i_q - CNT_W'(1);
	assign i_inc2  = i_q + CNT_W'(2);
	assign j_inc   = j_q + CNT_W'(1);
	assign j_dec   = j_q - CNT_W'(1);
	assign cnt_inc = cnt_q + CNT_W'(1);
	assign cnt_dec = cnt_q - CNT_W'(1);

	assign cnt_w  = CMP_W'(cnt_q);
	assign cap_w  = CMP_W'(cap);
	assign pos_w  = CMP_W'(req_q.position);
	assign pos_m1 = req_q.position - POS_W'(1);
	assign pos_c  = CNT_W'(req_q.position);

	// The usable capacity is the register value capped at the memory depth.
	assign full   = (cnt_w >= cap_w) || (cnt_w >= CMP_W'(CAPACITY));
	assign pos_nz = (req_q.position != '0);
	assign ins_ok = !full && pos_nz && (pos_w <= cnt_w + CMP_W'(1));
	assign del_ok = pos_nz && (pos_w <= cnt_w);

	assign is_insert = (req_q.action == ACT_INSERT);
	assign swap      = ($signed(cur_q) > $signed(mem_rdata));

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

	always_comb begin
		mem_req       = '0;
		mem_req.wdata = mem_rdata;
		case (state_q)
			ST_DEC: begin
				case (req_q.action)
					ACT_APPEND: begin
						mem_req.we    = !full;
						mem_req.waddr = cnt_q[IDX_W-1:0];
						mem_req.wdata = req_q.value;
					end
					ACT_DELETE: begin
						mem_req.raddr = IDX_W'(pos_m1);
					end
					default: begin
						mem_req.raddr = '0;
					end
				endcase
			end
			ST_MOVE: begin
				mem_req.we    = pend_q;
				mem_req.waddr = wdst_q;
				mem_req.raddr = i_q[IDX_W-1:0];
			end
			ST_INS_WR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = IDX_W'(pos_m1);
				mem_req.wdata = req_q.value;
			end
			ST_S_LDI: begin
				mem_req.raddr = i_inc[IDX_W-1:0];
			end
			ST_S_CMP: begin
				mem_req.we    = swap;
				mem_req.waddr = j_q[IDX_W-1:0];
				mem_req.wdata = cur_q;
				mem_req.raddr = j_inc[IDX_W-1:0];
			end
			ST_S_WRI: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = i_q[IDX_W-1:0];
				mem_req.wdata = cur_q;
				mem_req.raddr = i_inc[IDX_W-1:0];
			end
			ST_R_RDJ: begin
				mem_req.raddr = j_q[IDX_W-1:0];
			end
			ST_R_WRI: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = i_q[IDX_W-1:0];
			end
			ST_R_WRJ: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = j_q[IDX_W-1:0];
				mem_req.wdata = tmp_q;
				mem_req.raddr = i_inc[IDX_W-1:0];
			end
			ST_DUMP: begin
				mem_req.raddr = i_q[IDX_W-1:0];
			end
			default: begin
				mem_req.we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			req_q   <= '0;
			cnt_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
			rem_q   <= '0;
			pend_q  <= 1'b0;
			wdst_q  <= '0;
			cur_q   <= '0;
			tmp_q   <= '0;
			done_q  <= 1'b0;
			res_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						req_q   <= request;
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					state_q <= ST_IDLE;
					case (req_q.action)
						ACT_APPEND: begin
							done_q <= 1'b1;
							if (full) begin
								res_q <= mk_res(1'b0, '0, cnt_q, 1'b1);
							end else begin
								cnt_q <= cnt_inc;
								res_q <= mk_res(1'b1, '0, cnt_inc, 1'b1);
							end
						end
						ACT_INSERT: begin
							if (ins_ok) begin
								// Words from the position to the end move up by one.
								rem_q   <= cnt_q - (pos_c - CNT_W'(1));
								i_q     <= cnt_dec;
								pend_q  <= 1'b0;
								state_q <= ST_MOVE;
							end else begin
								done_q <= 1'b1;
								res_q  <= mk_res(1'b0, '0, cnt_q, 1'b1);
							end
						end
						ACT_DELETE: begin
							if (del_ok) begin
								state_q <= ST_DEL_LD;
							end else begin
								done_q <= 1'b1;
								res_q  <= mk_res(1'b0, '0, cnt_q, 1'b1);
							end
						end
						ACT_SORT: begin
							if (cnt_q > CNT_W'(1)) begin
								i_q     <= '0;
								state_q <= ST_S_LDI;
							end else begin
								done_q <= 1'b1;
								res_q  <= mk_res(1'b1, '0, cnt_q, 1'b1);
							end
						end
						ACT_REVERSE: begin
							if (cnt_q > CNT_W'(1)) begin
								i_q     <= '0;
								j_q     <= cnt_dec;
								state_q <= ST_R_RDJ;
							end else begin
								done_q <= 1'b1;
								res_q  <= mk_res(1'b1, '0, cnt_q, 1'b1);
							end
						end
						ACT_DUMP: begin
							if (cnt_q != '0) begin
								rem_q   <= cnt_q;
								i_q     <= '0;
								pend_q  <= 1'b0;
								state_q <= ST_DUMP;
							end else begin
								done_q <= 1'b1;
								res_q  <= mk_res(1'b0, '0, cnt_q, 1'b1);
							end
						end
						default: begin
							done_q <= 1'b1;
							res_q  <= mk_res(1'b0, '0, cnt_q, 1'b1);
						end
					endcase
				end
				ST_DEL_LD: begin
					// The removed word; the words above it then move down by one.
					tmp_q   <= mem_rdata;
					rem_q   <= cnt_q - pos_c;
					i_q     <= pos_c;
					pend_q  <= 1'b0;
					state_q <= ST_MOVE;
				end
				ST_MOVE: begin
					if (rem_q != '0) begin
						rem_q  <= rem_q - CNT_W'(1);
						pend_q <= 1'b1;
						if (is_insert) begin
							wdst_q <= i_inc[IDX_W-1:0];
							i_q    <= i_dec;
						end else begin
							wdst_q <= i_dec[IDX_W-1:0];
							i_q    <= i_inc;
						end
					end else begin
						pend_q <= 1'b0;
						if (is_insert) begin
							state_q <= ST_INS_WR;
						end else begin
							cnt_q   <= cnt_dec;
							done_q  <= 1'b1;
							res_q   <= mk_res(1'b1, tmp_q, cnt_dec, 1'b1);
							state_q <= ST_IDLE;
						end
					end
				end
				ST_INS_WR: begin
					cnt_q   <= cnt_inc;
					done_q  <= 1'b1;
					res_q   <= mk_res(1'b1, '0, cnt_inc, 1'b1);
					state_q <= ST_IDLE;
				end
				ST_S_LDI: begin
					cur_q   <= mem_rdata;
					j_q     <= i_inc;
					state_q <= ST_S_CMP;
				end
				ST_S_CMP: begin
					// cur_q holds the smallest word seen so far for slot i.
					if (swap) begin
						cur_q <= mem_rdata;
					end
					if (j_inc < cnt_q) begin
						j_q <= j_inc;
					end else begin
						state_q <= ST_S_WRI;
					end
				end
				ST_S_WRI: begin
					i_q <= i_inc;
					if (i_inc2 < cnt_q) begin
						state_q <= ST_S_LDI;
					end else begin
						done_q  <= 1'b1;
						res_q   <= mk_res(1'b1, '0, cnt_q, 1'b1);
						state_q <= ST_IDLE;
					end
				end
				ST_R_RDJ: begin
					tmp_q   <= mem_rdata;
					state_q <= ST_R_WRI;
				end
				ST_R_WRI: begin
					state_q <= ST_R_WRJ;
				end
				ST_R_WRJ: begin
					i_q <= i_inc;
					j_q <= j_dec;
					if (i_inc < j_dec) begin
						state_q <= ST_R_RDJ;
					end else begin
						done_q  <= 1'b1;
						res_q   <= mk_res(1'b1, '0, cnt_q, 1'b1);
						state_q <= ST_IDLE;
					end
				end
				ST_DUMP: begin
					if (rem_q != '0) begin
						rem_q  <= rem_q - CNT_W'(1);
						i_q    <= i_inc;
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
					if (pend_q) begin
						done_q <= 1'b1;
						res_q  <= mk_res(1'b1, mem_rdata, cnt_q, (rem_q == '0));
						if (rem_q == '0) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- sv/bounded_sequential_list.sv -----
// ----------------------------------------------------------------------------
// bounded_sequential_list: fixed-capacity ordered list of signed words
// Append, insert, delete, sort, reverse and dump over a 16-entry memory.
// ----------------------------------------------------------------------------
// A request transaction is taken when start is high and busy is low; busy then
// stays high until the action is complete. Results come out as single-cycle
// strobes on done with the fields on result, and the receiver cannot stall
// them: whoever is downstream must capture every result in the cycle that it
// appears. Every action gives exactly one result, except a dump of a non-empty
// list, which gives one result per stored word in order, back to back, with
// last set on the final one. All words live in one simple dual-port RAM (one
// read and one write per cycle, registered read data), so the cost of an
// action follows from how many RAM accesses it needs. Insert moves one word
// per cycle, and sort is an in-place selection sort. The next request can
// be accepted in the cycle that the final result is shown. The capacity
// register is written through the cfg channel, which is always ready; it
// should only be written while the block is idle. After reset the list is
// empty and the capacity is 16.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_sequential_list import bsl_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// Request channel.
	input  wire logic             start,
	output      logic             busy,
	input  wire req_t             request,
	// Result strobe.
	output      logic             done,
	output      res_t             result,
	// Capacity register write channel.
	input  wire logic             cfg_valid,
	output      logic             cfg_ready,
	input  wire logic [CFG_W-1:0] cfg_data
);

	logic [CFG_W-1:0] cap_q;
	mem_req_t         mem_req;
	word_t            mem_rdata;

	// The register is simple storage, so every write transaction is taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// The sequencer decodes each request and drives every RAM access.
	bsl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.cap       (cap_q),
		.done      (done),
		.result    (result),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	// Element storage. Entries beyond the current count are never used, so
	// the RAM needs no clearing after reset.
	bsl_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (WORD_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for bounded_sequential_list
// Drives list actions through the start/busy command port, writes the capacity
// register between phases, and checks every result strobe against an
// in-bench model of the list.
// ----------------------------------------------------------------------------

module tb;
	import bsl_pkg::*;

	// The longest wait for the list to go quiet, far beyond any correct drain.
	localparam int DRAIN_LIMIT = 4000;

	typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

	// One line of the directed table. A row either sends one request
	// transaction or writes the capacity register once the list is idle. Rows
	// with typed set carry their expected single result spelled out by hand.
	typedef struct {
		row_kind_t        kind;
		req_t             req;
		bit               typed;
		res_t             want;
		logic [CFG_W-1:0] cap;
	} stim_row_t;

	logic             clk;
	logic             arst_n    = 1'b0;
	logic             start     = 1'b0;
	req_t             request   = '0;
	logic             cfg_valid = 1'b0;
	logic [CFG_W-1:0] cfg_data  = '0;
	logic             busy;
	logic             done;
	res_t             result;
	logic             cfg_ready;

	// Model of the list: its words, how many are valid, and the capacity
	// register as last written.
	word_t            mdl_words [CAPACITY];
	int               mdl_count = 0;
	int               mdl_cap   = 16;

	// Results that the model says are still to come, oldest first.
	res_t             pending_results [$];
	int               fail_count = 0;

	// Hand-typed expectation for the request now on the port, if any.
	bit               row_typed = 1'b0;
	res_t             row_want  = '0;
	// Set during the stretch of stimulus that runs with no sender gaps.
	bit               no_idle   = 1'b0;

	stim_row_t        directed_rows [$];

	bounded_sequential_list u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Walks the model through one accepted request and queues the results it
	// causes. Every action gives one result except a dump of a non-empty list,
	// which gives one per stored word with last on the final one.
	function automatic void list_predict(input req_t r);
		int    cap_eff;
		int    pos;
		int    i;
		int    j;
		word_t tmp;
		res_t  res;
		cap_eff = (mdl_cap > CAPACITY) ? CAPACITY : mdl_cap;
		pos = int'(r.position);
		res = '{ok: 1'b0, data: '0, count: '0, last: 1'b1};
		case (r.action)
			ACT_APPEND: begin
				// A full list, or a capacity of zero, refuses the word.
				if (mdl_count < cap_eff) begin
					mdl_words[mdl_count] = r.value;
					mdl_count++;
					res.ok = 1'b1;
				end
			end
			ACT_INSERT: begin
				if (mdl_count < cap_eff && pos >= 1 && pos <= mdl_count + 1) begin
					for (i = mdl_count; i >= pos; i--)
						mdl_words[i] = mdl_words[i - 1];
					mdl_words[pos - 1] = r.value;
					mdl_count++;
					res.ok = 1'b1;
				end
			end
			ACT_DELETE: begin
				if (mdl_count > 0 && pos >= 1 && pos <= mdl_count) begin
					res.data = mdl_words[pos - 1];
					for (i = pos - 1; i + 1 < mdl_count; i++)
						mdl_words[i] = mdl_words[i + 1];
					mdl_count--;
					res.ok = 1'b1;
				end
			end
			ACT_SORT: begin
				// Ascending in signed order; an empty list still succeeds.
				for (i = 0; i < mdl_count; i++)
					for (j = i + 1; j < mdl_count; j++)
						if (mdl_words[i] > mdl_words[j]) begin
							tmp = mdl_words[i];
							mdl_words[i] = mdl_words[j];
							mdl_words[j] = tmp;
						end
				res.ok = 1'b1;
			end
			ACT_REVERSE: begin
				for (i = 0, j = mdl_count - 1; i < j; i++, j--) begin
					tmp = mdl_words[i];
					mdl_words[i] = mdl_words[j];
					mdl_words[j] = tmp;
				end
				res.ok = 1'b1;
			end
			ACT_DUMP: begin
				if (mdl_count > 0) begin
					for (i = 0; i < mdl_count; i++) begin
						res.ok = 1'b1;
						res.data = mdl_words[i];
						res.count = COUNT_W'(mdl_count);
						res.last = (i + 1 == mdl_count);
						pending_results.push_back(res);
					end
					return;
				end
			end
			default: begin
				// Codes 6 and 7 are not actions: the list is left alone.
			end
		endcase
		res.count = COUNT_W'(mdl_count);
		pending_results.push_back(res);
	endfunction

	// Everything that happens at a rising edge is judged here, on the values
	// that the inputs and outputs held just before it. A result is checked
	// before a request taken at the same edge is predicted, because the block
	// may accept the next request in the cycle that shows its final result.
	always @(posedge clk) begin
		int   slot;
		res_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_results.size() == 0) begin
					$error("result with no expectation: ok %0b data %0d count %0d last %0b",
						result.ok, result.data, result.count, result.last);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					if (result.ok !== want.ok) begin
						$error("ok: expected %0b, actual %0b", want.ok, result.ok);
						fail_count++;
					end
					if (result.data !== want.data) begin
						$error("data: expected %0d, actual %0d", want.data, result.data);
						fail_count++;
					end
					if (result.count !== want.count) begin
						$error("count: expected %0d, actual %0d", want.count, result.count);
						fail_count++;
					end
					if (result.last !== want.last) begin
						$error("last: expected %0b, actual %0b", want.last, result.last);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				mdl_cap = int'(cfg_data);
			if (start && !busy) begin
				slot = pending_results.size();
				list_predict(request);
				// A typed row replaces the model's single result with the
				// value written into the table, while the model still keeps
				// track of the list contents.
				if (row_typed)
					pending_results[slot] = row_want;
			end
		end
	end

	// Presents one request transaction and returns at the edge that takes
	// it. About a quarter of the requests are preceded by a gap of random
	// length, so the gaps land at every stage of the work on the last one.
	task automatic send_item(input req_t r, input bit typed, input res_t want);
		int gap;
		if (!no_idle && $urandom_range(99) < 24) begin
			gap = $urandom_range(1, 12);
			repeat (gap) begin
				@(negedge clk);
				start <= 1'b0;
			end
		end
		@(negedge clk);
		start     <= 1'b1;
		request   <= r;
		row_typed  = typed;
		row_want   = want;
		do @(posedge clk); while (busy);
	endtask

	// Stops sending and waits until every expected result has arrived and
	// the block is idle, then lets the requested extra cycles pass. Results still
	// missing after the limit are reported and dropped so the run can go on.
	task automatic drain_list(input int extra);
		int waited;
		@(negedge clk);
		start <= 1'b0;
		waited = 0;
		while ((pending_results.size() != 0 || busy) && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			fail_count++;
			pending_results.delete();
		end
		repeat (extra) @(posedge clk);
	endtask

	// The capacity register is only touched while the list is idle.
	task automatic write_capacity(input logic [CFG_W-1:0] cap);
		drain_list(8);
		repeat ($urandom_range(0, 3)) @(negedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= cap;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic stim_row_t item_row(input action_t a, input int pos, input word_t v);
		stim_row_t row;
		row = '{kind: ROW_ITEM, req: '0, typed: 1'b0, want: '0, cap: '0};
		row.req.action   = a;
		row.req.position = POS_W'(pos);
		row.req.value    = v;
		return row;
	endfunction

	// A row whose single result is plain to see: data is always zero here.
	function automatic stim_row_t typed_row(input action_t a, input int pos, input word_t v,
			input logic ok, input int cnt);
		stim_row_t row;
		row = item_row(a, pos, v);
		row.typed = 1'b1;
		row.want  = '{ok: ok, data: '0, count: COUNT_W'(cnt), last: 1'b1};
		return row;
	endfunction

	function automatic stim_row_t cfg_row(input logic [CFG_W-1:0] cap);
		stim_row_t row;
		row = '{kind: ROW_CFG, req: '0, typed: 1'b0, want: '0, cap: cap};
		return row;
	endfunction

	// Random requests: mostly appends and inserts so the list fills up and
	// hits the full case, with positions mostly in range and now and then
	// anywhere in the five-bit field. A few requests carry the unused codes.
	function automatic req_t random_request();
		req_t r;
		int   pick;
		pick = $urandom_range(99);
		r.value = word_t'($urandom);
		if ($urandom_range(9) == 0) begin
			case ($urandom_range(3))
				0: r.value = 32'sh7fffffff;
				1: r.value = 32'sh80000000;
				2: r.value = '0;
				default: r.value = -32'sd1;
			endcase
		end
		if (pick < 30)
			r.action = ACT_APPEND;
		else if (pick < 55)
			r.action = ACT_INSERT;
		else if (pick < 75)
			r.action = ACT_DELETE;
		else if (pick < 82)
			r.action = ACT_SORT;
		else if (pick < 89)
			r.action = ACT_REVERSE;
		else if (pick < 97)
			r.action = ACT_DUMP;
		else
			r.action = action_t'(3'($urandom_range(6, 7)));
		if ($urandom_range(4) == 0)
			r.position = POS_W'($urandom);
		else
			r.position = POS_W'($urandom_range(1, mdl_count + 1));
		return r;
	endfunction

	initial begin
		int               p;
		logic [CFG_W-1:0] phase_cap;

		// Directed table. The list contents are tracked in the comments.
		directed_rows.push_back(typed_row(ACT_DUMP,    0, 0, 1'b0, 0));  // empty dump
		directed_rows.push_back(typed_row(ACT_DELETE,  1, 0, 1'b0, 0));  // empty delete
		directed_rows.push_back(typed_row(ACT_SORT,    0, 0, 1'b1, 0));  // empty sort
		directed_rows.push_back(typed_row(ACT_REVERSE, 0, 0, 1'b1, 0));  // empty reverse
		directed_rows.push_back(typed_row(ACT_INSERT,  0, 1234, 1'b0, 0));  // position zero
		directed_rows.push_back(typed_row(ACT_INSERT,  2, 1234, 1'b0, 0));  // past count+1
		directed_rows.push_back(typed_row(ACT_INSERT,  1, 32'sh7fffffff, 1'b1, 1));
		directed_rows.push_back(typed_row(ACT_APPEND,  0, 32'sh80000000, 1'b1, 2));
		directed_rows.push_back(typed_row(ACT_APPEND, 31, 0, 1'b1, 3));  // position ignored
		directed_rows.push_back(typed_row(ACT_INSERT,  4, -32'sd1, 1'b1, 4));  // at count+1
		directed_rows.push_back(typed_row(ACT_INSERT,  2, 5, 1'b1, 5));
		// List: max, 5, min, 0, -1. Unused codes leave it alone.
		directed_rows.push_back(typed_row(action_t'(3'd6), 0, 0, 1'b0, 5));
		directed_rows.push_back(typed_row(action_t'(3'd7), 31, -32'sd1, 1'b0, 5));
		directed_rows.push_back(item_row(ACT_DUMP, 0, 0));
		directed_rows.push_back(typed_row(ACT_SORT,    0, 0, 1'b1, 5));
		directed_rows.push_back(typed_row(ACT_REVERSE, 0, 0, 1'b1, 5));
		directed_rows.push_back(item_row(ACT_DUMP, 0, 0));
		directed_rows.push_back(typed_row(ACT_DELETE,  6, 0, 1'b0, 5));  // past count
		directed_rows.push_back(item_row(ACT_DELETE, 5, 0));  // last word
		directed_rows.push_back(item_row(ACT_DELETE, 1, 0));  // first word
		directed_rows.push_back(typed_row(ACT_INSERT, 31, 7, 1'b0, 3));
		// A capacity of zero refuses every new word but still allows delete.
		directed_rows.push_back(cfg_row(CFG_W'(0)));
		directed_rows.push_back(typed_row(ACT_APPEND, 0, 9, 1'b0, 3));
		directed_rows.push_back(typed_row(ACT_INSERT, 1, 9, 1'b0, 3));
		directed_rows.push_back(item_row(ACT_DELETE, 2, 0));
		// Capacity below the count: the stored words stay and can be dumped.
		directed_rows.push_back(cfg_row(CFG_W'(1)));
		directed_rows.push_back(typed_row(ACT_APPEND, 0, 9, 1'b0, 2));
		directed_rows.push_back(item_row(ACT_DUMP, 0, 0));
		// Capacity above the array size is capped at the array size.
		directed_rows.push_back(cfg_row(CFG_W'(31)));
		directed_rows.push_back(typed_row(ACT_APPEND, 0, -32'sd2, 1'b1, 3));

		// Reset is held from time zero and let go at a falling edge.
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[k]) begin
			if (directed_rows[k].kind == ROW_CFG)
				write_capacity(directed_rows[k].cap);
			else
				send_item(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].want);
		end

		// Random phases, each under its own capacity. The list carries over
		// from phase to phase, so later phases start with it well filled and
		// a small capacity meets a count already above it. Each phase begins
		// only after every result of the one before has come back. The
		// second phase runs with no gaps at all.
		for (p = 0; p < 5; p++) begin
			case (p)
				0: phase_cap = CFG_W'(16);
				1: phase_cap = CFG_W'(31);
				2: phase_cap = CFG_W'($urandom_range(1, 31));
				3: phase_cap = CFG_W'(1);
				default: phase_cap = CFG_W'(16);
			endcase
			write_capacity(phase_cap);
			no_idle = (p == 1);
			repeat (21)
				send_item(random_request(), 1'b0, '0);
		end
		no_idle = 1'b0;

		drain_list(20);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// A correct run needs well under 200 microseconds.
	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/bsl_pkg.sv
sv/bsl_ram.sv
sv/bsl_ctrl.sv
sv/bounded_sequential_list.sv
tb/tb.sv
